/* sv/cosine_taylor_series_unit_macros.svh */
// assertion helpers used by cosine_taylor_series_unit.sv
// both expect clk and rst_n in the enclosing scope
`ifndef COSINE_TAYLOR_SERIES_UNIT_MACROS_SVH
`define COSINE_TAYLOR_SERIES_UNIT_MACROS_SVH

// same-cycle implication
`define CTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* sv/cts_pkg.sv */
`timescale 1ns / 1ps
package cts_pkg;

  // term count bound
  localparam int MAX_TERMS = 16;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int CNT_W   = 5;
  localparam int COS_W   = 32;

  // largest count the 5-bit field can carry after the bound
  localparam int CNT_LIM = (MAX_TERMS > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : MAX_TERMS;

  // datapath widths
  localparam int SQ_W   = 2 * ANGLE_W - 9;    // (angle*angle) >> 8, never negative
  localparam int TERM_W = 32;
  localparam int PROD_W = TERM_W + SQ_W + 1;  // term times zero-extended square
  localparam int FRAC_W = 16;
  localparam int DIV_W  = 32;                 // magnitude of the shifted product
  localparam int DEN_W  = 2 * (CNT_W + 1);    // (2k-1)*(2k)

  // 1.0 in Q15.16
  localparam logic signed [TERM_W-1:0] ONE_Q16 = TERM_W'(65536);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_ACC,
    ST_DONE
  } cts_state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* sv/cts_divider.sv */
`timescale 1ns / 1ps
module cts_divider (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [cts_pkg::DIV_W-1:0]        dividend,
  input  logic [cts_pkg::DEN_W-1:0]        divisor,
  output logic [cts_pkg::DIV_W-1:0]        quotient,
  output cts_pkg::div_status_t             stat
);
  import cts_pkg::*;

  localparam int STEP_W = $clog2(DIV_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // one restoring step per cycle, dividend bits shift out into the remainder as quotient bits shift in
  always_comb begin
    trial    = {rem_r, quo_r[DIV_W-1]};
    diff     = trial - {1'b0, den_r};
    fits     = (trial >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[DIV_W-2:0], fits};
      rem_nxt  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* sv/cosine_taylor_series_unit.sv */
`timescale 1ns / 1ps
// Truncated cosine series: takes a Q3.12 angle and a term count (clamped to the
// term bound) and returns 1 - x^2/2! + x^4/4! - ... in Q15.16, one result per
// input. A count of zero or one gives 1.0 without a divider pass. Each further
// term runs a multiply, a divider setup, a wait on the 32-step bit-serial
// divider, an accumulate and a loop test; the divider dominates each term. Input
// is taken only when the sequencer is idle; a finished result sits in the
// output register and does not hold off the next input transfer.
module cosine_taylor_series_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] angle, [20:16] term_count, [23:21] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] cosine
);
  import cts_pkg::*;

  `include "cosine_taylor_series_unit_macros.svh"

  cts_state_t state_r, state_nxt;

  logic                     div_start;
  logic                     out_load;
  logic [DIV_W-1:0]         div_dividend;
  logic [DEN_W-1:0]         div_divisor;
  logic [DIV_W-1:0]         div_quo;
  div_status_t              div_stat;

  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;
  logic signed [TERM_W-1:0] term_r, term_nxt;
  logic signed [COS_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     qneg_r, qneg_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [COS_W-1:0]         out_data_r, out_data_nxt;

  logic signed [ANGLE_W-1:0]   angle;
  logic [CNT_W-1:0]            tc;
  logic signed [2*ANGLE_W-1:0] asq;
  logic signed [PROD_W-1:0]    p_shift;
  logic signed [PROD_W-1:0]    p_mag;
  logic [CNT_W:0]              twok;
  logic [CNT_W:0]              twok_m1;
  logic signed [TERM_W-1:0]    q_s;
  logic signed [TERM_W-1:0]    term_acc;
  logic signed [COS_W:0]       sum_ext;

  // shared serial divider
  cts_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_TEST;
      ST_TEST:      state_nxt = (k_r < cnt_r) ? ST_MUL : ST_DONE;
      ST_MUL:       state_nxt = ST_DIV_START;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_stat.done) state_nxt = ST_ACC;
      ST_ACC:       state_nxt = ST_TEST;
      ST_DONE:      if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE:      in_tready = 1'b1;
      ST_DIV_START: div_start = 1'b1;
      ST_DONE:      out_load  = !out_valid_r || out_tready;
      default:      ;
    endcase
  end

  // input unpacking and square of the angle
  assign angle = $signed(in_tdata[ANGLE_W-1:0]);
  assign tc    = in_tdata[ANGLE_W+CNT_W-1:ANGLE_W];
  assign asq   = (2*ANGLE_W)'(angle) * (2*ANGLE_W)'(angle);

  // shifted product magnitude and denominator for the divider
  assign p_shift      = prod_r >>> FRAC_W;
  assign p_mag        = p_shift[PROD_W-1] ? -p_shift : p_shift;
  assign div_dividend = p_mag[DIV_W-1:0];
  assign twok         = {k_r, 1'b0};
  assign twok_m1      = twok - 1'b1;
  assign div_divisor  = DEN_W'(twok_m1) * DEN_W'(twok);

  // signed quotient and saturating sum
  assign q_s      = $signed(div_quo);
  assign term_acc = qneg_r ? -q_s : q_s;
  assign sum_ext  = {sum_r[COS_W-1], sum_r} + {{(COS_W+1-TERM_W){term_acc[TERM_W-1]}}, term_acc};

  // datapath updates
  always_comb begin
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    sq_nxt   = sq_r;
    term_nxt = term_r;
    sum_nxt  = sum_r;
    prod_nxt = prod_r;
    qneg_nxt = qneg_r;
    if (in_tvalid && in_tready) begin
      cnt_nxt  = (tc > CNT_W'(CNT_LIM)) ? CNT_W'(CNT_LIM) : tc;
      k_nxt    = CNT_W'(1);
      sq_nxt   = asq[SQ_W+7:8];
      term_nxt = ONE_Q16;
      sum_nxt  = COS_W'(ONE_Q16);
    end
    if (state_r == ST_MUL) begin
      prod_nxt = PROD_W'(term_r) * PROD_W'($signed({1'b0, sq_r}));
    end
    if (state_r == ST_DIV_START) begin
      // the next term carries the opposite sign of the shifted product
      qneg_nxt = !p_shift[PROD_W-1];
    end
    if (state_r == ST_ACC) begin
      term_nxt = term_acc;
      k_nxt    = k_r + 1'b1;
      if (sum_ext[COS_W] != sum_ext[COS_W-1]) begin
        sum_nxt = sum_ext[COS_W] ? {1'b1, {(COS_W-1){1'b0}}} : {1'b0, {(COS_W-1){1'b1}}};
      end else begin
        sum_nxt = sum_ext[COS_W-1:0];
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tvalid && out_tready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = sum_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    k_r        <= k_nxt;
    sq_r       <= sq_nxt;
    term_r     <= term_nxt;
    sum_r      <= sum_nxt;
    prod_r     <= prod_nxt;
    qneg_r     <= qneg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks on the sequencer and divider hand-off
  `CTS_ASSERT_IMP(a_ready_div_idle, in_tready, !div_stat.busy)
  `CTS_ASSERT_IMP(a_start_div_idle, div_start, !div_stat.busy && !div_stat.done)
  `CTS_ASSERT_IMP(a_done_in_wait, div_stat.done, state_r == ST_DIV_WAIT)
  `CTS_ASSERT_IMP(a_acc_in_range, state_r == ST_ACC, k_r < cnt_r)
  `CTS_ASSERT_NXT(a_start_busy, div_start, div_stat.busy)

endmodule
